// ----- rtl/deq_pkg.sv -----
// Shared request and status codes for the double-ended queue.
package deq_pkg;

  localparam int unsigned ReqWidth    = 3;
  localparam int unsigned StatusWidth = 2;

  localparam logic [ReqWidth-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [ReqWidth-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [ReqWidth-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [ReqWidth-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [ReqWidth-1:0] REQ_REVERSE    = 3'd4;
  localparam logic [ReqWidth-1:0] REQ_CLEAR      = 3'd5;

  localparam logic [StatusWidth-1:0] STATUS_DONE      = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_OVERFLOW  = 2'd2;

endpackage

// ----- rtl/double_ended_queue_core.sv -----
// Bounded double-ended queue: ring RAM, end-word registers and response stage.
// Each accepted request passes through the DONE state to the output register;
//   a pop leaving two or more entries first refetches the new end word over
//   the single registered RAM read port in the READ state, stalling input.
// Throughput: one transaction per cycle while the response is not stalled.
// Reset: asynchronous, clears head, count and direction; RAM is not cleared.
module double_ended_queue_core #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [deq_pkg::ReqWidth-1:0]    req_type_i,
  input  logic [DATA_WIDTH-1:0]           push_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [DATA_WIDTH-1:0]           front_value_o,
  output logic [DATA_WIDTH-1:0]           back_value_o,
  output logic [$clog2(DEPTH+1)-1:0]      entry_count_o,
  output logic                            is_empty_o,
  output logic [deq_pkg::StatusWidth-1:0] status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  logic [1:0]                      state_q, state_d;
  logic [AW-1:0]                   head_q, head_d;
  logic [CW-1:0]                   cnt_q, cnt_d;
  logic                            rev_q, rev_d;
  logic [DATA_WIDTH-1:0]           first_q, first_d;
  logic [DATA_WIDTH-1:0]           last_q, last_d;
  logic [deq_pkg::StatusWidth-1:0] status_q, status_d;
  logic                            tgt_first_q, tgt_first_d;

  logic                  accept, out_free, out_load, need_read;
  logic                  is_full, is_empty, at_start;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] res_front, res_back;

  assign out_load   = (state_q == ST_DONE) && out_free;
  assign in_stall_o = !((state_q == ST_IDLE) || out_load);
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = (cnt_q == CW'(DEPTH));
  assign is_empty = (cnt_q == '0);

  always_comb begin
    head_d      = head_q;
    cnt_d       = cnt_q;
    rev_d       = rev_q;
    first_d     = first_q;
    last_d      = last_q;
    status_d    = status_q;
    tgt_first_d = tgt_first_q;
    we          = 1'b0;
    waddr       = ring_add(head_q, cnt_q);
    re          = 1'b0;
    raddr       = ring_inc(head_q);
    need_read   = 1'b0;
    at_start    = 1'b0;

    if (state_q == ST_READ) begin
      if (tgt_first_q) begin
        first_d = rdata;
      end else begin
        last_d = rdata;
      end
    end

    if (accept) begin
      status_d = deq_pkg::STATUS_DONE;
      case (req_type_i)
        deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_BACK: begin
          at_start = (req_type_i == deq_pkg::REQ_PUSH_FRONT) != rev_q;
          if (is_full) begin
            status_d = deq_pkg::STATUS_OVERFLOW;
          end else begin
            we    = 1'b1;
            cnt_d = cnt_q + CW'(1);
            if (at_start) begin
              head_d  = ring_dec(head_q);
              waddr   = ring_dec(head_q);
              first_d = push_value_i;
              if (is_empty) begin
                last_d = push_value_i;
              end
            end else begin
              last_d = push_value_i;
              if (is_empty) begin
                first_d = push_value_i;
              end
            end
          end
        end
        deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_POP_BACK: begin
          at_start = (req_type_i == deq_pkg::REQ_POP_FRONT) != rev_q;
          if (is_empty) begin
            status_d = deq_pkg::STATUS_UNDERFLOW;
          end else begin
            cnt_d = cnt_q - CW'(1);
            if (at_start) begin
              head_d = ring_inc(head_q);
              if (cnt_q == CW'(2)) begin
                first_d = last_q;
              end
            end else if (cnt_q == CW'(2)) begin
              last_d = first_q;
            end
            if (cnt_q > CW'(2)) begin
              need_read   = 1'b1;
              re          = 1'b1;
              tgt_first_d = at_start;
              raddr       = at_start ? ring_inc(head_q) : ring_add(head_q, cnt_q - CW'(2));
            end
          end
        end
        deq_pkg::REQ_REVERSE: begin
          rev_d = !rev_q;
        end
        deq_pkg::REQ_CLEAR: begin
          cnt_d  = '0;
          head_d = '0;
          rev_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = need_read ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (accept) begin
          state_d = need_read ? ST_READ : ST_DONE;
        end else if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      rev_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      rev_q   <= rev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q     <= first_d;
    last_q      <= last_d;
    status_q    <= status_d;
    tgt_first_q <= tgt_first_d;
  end

  deq_ram #(
    .Width(DATA_WIDTH),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(push_value_i),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign res_front = is_empty ? '0 : (rev_q ? last_q : first_q);
  assign res_back  = is_empty ? '0 : (rev_q ? first_q : last_q);

  deq_outreg #(
    .DataWidth (DATA_WIDTH),
    .CountWidth(CW)
  ) u_outreg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (out_load),
    .front_i      (res_front),
    .back_i       (res_back),
    .count_i      (cnt_q),
    .empty_i      (is_empty),
    .status_i     (status_q),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .front_value_o(front_value_o),
    .back_value_o (back_value_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .status_o     (status_o)
  );

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_DONE))
    else $error("refetch did not complete in one cycle");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == deq_pkg::STATUS_OVERFLOW)) |-> (entry_count_o == CW'(DEPTH)))
    else $error("overflow reported while not full");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> ((front_value_o == '0) && (back_value_o == '0)))
    else $error("empty response carries nonzero words");
`endif

endmodule

// ----- rtl/deq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module deq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/deq_outreg.sv -----
// Output register stage for the queue response channel.
module deq_outreg #(
  parameter int unsigned DataWidth  = 64,
  parameter int unsigned CountWidth = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic [DataWidth-1:0]            front_i,
  input  logic [DataWidth-1:0]            back_i,
  input  logic [CountWidth-1:0]           count_i,
  input  logic                            empty_i,
  input  logic [deq_pkg::StatusWidth-1:0] status_i,
  output logic                            free_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [DataWidth-1:0]            front_value_o,
  output logic [DataWidth-1:0]            back_value_o,
  output logic [CountWidth-1:0]           entry_count_o,
  output logic                            is_empty_o,
  output logic [deq_pkg::StatusWidth-1:0] status_o
);

  logic                            valid_q, valid_d;
  logic [DataWidth-1:0]            front_q, back_q;
  logic [CountWidth-1:0]           count_q;
  logic                            empty_q;
  logic [deq_pkg::StatusWidth-1:0] status_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      front_q  <= front_i;
      back_q   <= back_i;
      count_q  <= count_i;
      empty_q  <= empty_i;
      status_q <= status_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign front_value_o = front_q;
  assign back_value_o  = back_q;
  assign entry_count_o = count_q;
  assign is_empty_o    = empty_q;
  assign status_o      = status_q;

endmodule
